// File: hdl/fmmp_pkg.sv
// Shared types, constants and helpers for the Fibonacci matrix power block.
// Holds the residue type, the modulus, the controller states and the
// command and status structs between controller and datapath.
`default_nettype none

package fmmp_pkg;

	localparam int RES_W = 30;
	typedef logic [RES_W-1:0] res_t;

	localparam res_t FIB_MOD = 30'd1000000007;

	// Barrett factor floor(2^62 / P), used with the top 32 bits of a product.
	localparam logic [32:0] BARRETT_MU = 33'((64'd1 << 62) / 64'd1000000007);

	// Product slots in the datapath.
	localparam int NUM_SLOTS = 5;
	typedef logic [2:0] slot_t;
	localparam slot_t SLOT_AA = 3'd0;
	localparam slot_t SLOT_BB = 3'd1;
	localparam slot_t SLOT_AB = 3'd2;
	localparam slot_t SLOT_BD = 3'd3;
	localparam slot_t SLOT_DD = 3'd4;

	typedef enum logic [2:0] {
		MS_AA,
		MS_BB,
		MS_AB,
		MS_BD,
		MS_DD,
		MS_A3,
		MS_B2
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_SQ_ISSUE,
		ST_SQ_WAIT,
		ST_SQ_UPD,
		ST_MULQ,
		ST_FIN_ISSUE,
		ST_FIN_WAIT,
		ST_FIN_ADD
	} fmmp_state_t;

	typedef struct packed {
		logic     load;
		logic     norm_shift;
		logic     mul_go;
		mul_sel_t mul_sel;
		logic     sq_update;
		logic     q_update;
		logic     result_load;
	} fmmp_cmd_t;

	typedef struct packed {
		logic small_n;
		logic top_set;
		logic cnt_zero;
		logic cnt_one;
		logic exp_bit;
		logic mul_idle;
	} fmmp_status_t;

	function automatic res_t mod_add(res_t x, res_t y);
		logic [RES_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, FIB_MOD}) begin
			s = s - {1'b0, FIB_MOD};
		end
		return s[RES_W-1:0];
	endfunction

	// The two products of the final step reuse the first two slots.
	function automatic slot_t sel_slot(mul_sel_t sel);
		slot_t slot;
		case (sel)
			MS_AA:   slot = SLOT_AA;
			MS_BB:   slot = SLOT_BB;
			MS_AB:   slot = SLOT_AB;
			MS_BD:   slot = SLOT_BD;
			MS_DD:   slot = SLOT_DD;
			MS_A3:   slot = SLOT_AA;
			MS_B2:   slot = SLOT_BB;
			default: slot = SLOT_AA;
		endcase
		return slot;
	endfunction

endpackage

`default_nettype wire

// File: hdl/fmmp_index_if.sv
// Input channel of the Fibonacci matrix power block: valid, ready, index.
// Stands alone; its width is set by its own INDEX_BITS parameter.
`default_nettype none

interface fmmp_index_if #(
	parameter int INDEX_BITS = 63
) ();
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] index;

	modport source (output valid, output index, input ready);
	modport sink (input valid, input index, output ready);
endinterface

`default_nettype wire

// File: hdl/fmmp_count_if.sv
// Result channel of the Fibonacci matrix power block: valid, ready, count_mod.
// Depends on fmmp_pkg for the residue type.
`default_nettype none

interface fmmp_count_if import fmmp_pkg::*; ();
	logic valid;
	logic ready;
	res_t count_mod;

	modport source (output valid, output count_mod, input ready);
	modport sink (input valid, input count_mod, output ready);
endinterface

`default_nettype wire

// File: hdl/fibonacci_mod_matrix_power.sv
// Top level of the Fibonacci matrix power block: controller, datapath and
// the two stream channels. Depends on fmmp_pkg, fmmp_index_if, fmmp_count_if,
// fmmp_ctrl and fmmp_datapath.
//
// Each transfer on req carries a length n; one transfer on rsp returns the
// number of binary strings of length n without two adjacent zeros, modulo
// 1000000007 (0, 2 and 3 for n = 0, 1, 2). Only the low INDEX_BITS bits of n
// count. Items are worked one at a time. After the accepting cycle, the
// exponent n-2 is normalized at one bit a cycle until its leading one reaches
// the top, then each lower bit takes five products issued into the shared
// four-stage modular multiplier, the drain, and the update, followed by a
// multiply by Q for a one bit. Small lengths skip straight to the final
// combination, which issues two more products and adds them. The result
// sits in an output register, and a new item is taken while it waits on rsp.
`default_nettype none

module fibonacci_mod_matrix_power import fmmp_pkg::*; #(
	parameter int INDEX_BITS = 63
) (
	input  logic         clk,
	input  logic         arst_n,
	fmmp_index_if.sink   req,
	fmmp_count_if.source rsp
);

	fmmp_cmd_t    cmd;
	fmmp_status_t status;

	fmmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	fmmp_datapath #(
		.INDEX_BITS (INDEX_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.index     (req.index[INDEX_BITS-1:0]),
		.cmd       (cmd),
		.status    (status),
		.count_mod (rsp.count_mod)
	);

endmodule

`default_nettype wire

// File: hdl/fmmp_mulmod.sv
// Pipelined modular multiplier: a*b mod P with a Barrett estimate.
// Depends on fmmp_pkg for the modulus, the Barrett factor and the slot type.
`default_nettype none

module fmmp_mulmod import fmmp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  res_t  in_a,
	input  res_t  in_b,
	input  slot_t in_slot,
	output logic  out_valid,
	output res_t  out_y,
	output slot_t out_slot,
	output logic  idle
);

	localparam logic [31:0] MOD_W32 = {2'b00, FIB_MOD};

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [59:0] x_s1;
	slot_t       slot_s1, slot_s2, slot_s3, slot_s4;
	logic [64:0] t_s2;
	logic [31:0] xlo_s2, xlo_s3;
	logic [59:0] qp_s3;
	logic [31:0] r_s4;
	logic [31:0] diff;
	logic [31:0] fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// The quotient estimate never exceeds the true quotient and falls short
	// by at most two, so the remainder needs two conditional subtractions.
	assign diff = xlo_s3 - qp_s3[31:0];

	always_ff @(posedge clk) begin
		x_s1    <= {30'd0, in_a} * {30'd0, in_b};
		slot_s1 <= in_slot;
		t_s2    <= {33'd0, x_s1[59:28]} * {32'd0, BARRETT_MU};
		xlo_s2  <= x_s1[31:0];
		slot_s2 <= slot_s1;
		qp_s3   <= {30'd0, t_s2[63:34]} * {30'd0, FIB_MOD};
		xlo_s3  <= xlo_s2;
		slot_s3 <= slot_s2;
		r_s4    <= (diff >= MOD_W32) ? (diff - MOD_W32) : diff;
		slot_s4 <= slot_s3;
	end

	assign fin       = (r_s4 >= MOD_W32) ? (r_s4 - MOD_W32) : r_s4;
	assign out_y     = fin[RES_W-1:0];
	assign out_valid = v_s4;
	assign out_slot  = slot_s4;
	assign idle      = !(v_s1 || v_s2 || v_s3 || v_s4);

endmodule

`default_nettype wire

// File: hdl/fmmp_datapath.sv
// Datapath: exponent scan register, the symmetric power matrix, product
// slots and the result register. Depends on fmmp_pkg and fmmp_mulmod.
`default_nettype none

module fmmp_datapath import fmmp_pkg::*; #(
	parameter int INDEX_BITS = 63
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [INDEX_BITS-1:0] index,
	input  fmmp_cmd_t             cmd,
	output fmmp_status_t          status,
	output res_t                  count_mod
);

	localparam int CW = $clog2(INDEX_BITS);
	localparam logic [CW-1:0] CNT_INIT = CW'(INDEX_BITS - 1);

	// The power of Q is symmetric, so only a, b (= c) and d are kept.
	logic [INDEX_BITS-1:0] e_q;
	logic [CW-1:0]         cnt_q;
	logic                  small_q;
	res_t                  a_q, b_q, d_q;
	res_t                  prod_q [NUM_SLOTS];
	res_t                  count_q;

	res_t  mul_a, mul_b;
	logic  mo_valid;
	res_t  mo_y;
	slot_t mo_slot;
	logic  mul_idle;

	always_comb begin
		case (cmd.mul_sel)
			MS_AA: begin
				mul_a = a_q;
				mul_b = a_q;
			end
			MS_BB: begin
				mul_a = b_q;
				mul_b = b_q;
			end
			MS_AB: begin
				mul_a = a_q;
				mul_b = b_q;
			end
			MS_BD: begin
				mul_a = b_q;
				mul_b = d_q;
			end
			MS_DD: begin
				mul_a = d_q;
				mul_b = d_q;
			end
			MS_A3: begin
				mul_a = a_q;
				mul_b = res_t'(3);
			end
			MS_B2: begin
				mul_a = b_q;
				mul_b = res_t'(2);
			end
			default: begin
				mul_a = a_q;
				mul_b = a_q;
			end
		endcase
	end

	fmmp_mulmod u_mulmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.mul_go),
		.in_a      (mul_a),
		.in_b      (mul_b),
		.in_slot   (sel_slot(cmd.mul_sel)),
		.out_valid (mo_valid),
		.out_y     (mo_y),
		.out_slot  (mo_slot),
		.idle      (mul_idle)
	);

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (mo_valid && mo_slot == slot_t'(i)) begin
				prod_q[i] <= mo_y;
			end
		end

		if (cmd.load) begin
			small_q <= (index < INDEX_BITS'(3));
			e_q     <= index - INDEX_BITS'(2);
			cnt_q   <= CNT_INIT;
			d_q     <= '0;
			// The small lengths are loaded so that 3*a + 2*b gives their answer.
			if (index == INDEX_BITS'(0)) begin
				a_q <= res_t'(0);
				b_q <= res_t'(0);
			end else if (index == INDEX_BITS'(1)) begin
				a_q <= res_t'(0);
				b_q <= res_t'(1);
			end else if (index == INDEX_BITS'(2)) begin
				a_q <= res_t'(1);
				b_q <= res_t'(0);
			end else begin
				a_q <= res_t'(1);
				b_q <= res_t'(1);
			end
		end else if (cmd.norm_shift) begin
			e_q   <= e_q << 1;
			cnt_q <= cnt_q - CW'(1);
		end else if (cmd.sq_update) begin
			a_q   <= mod_add(prod_q[SLOT_AA], prod_q[SLOT_BB]);
			b_q   <= mod_add(prod_q[SLOT_AB], prod_q[SLOT_BD]);
			d_q   <= mod_add(prod_q[SLOT_BB], prod_q[SLOT_DD]);
			e_q   <= e_q << 1;
			cnt_q <= cnt_q - CW'(1);
		end else if (cmd.q_update) begin
			a_q <= mod_add(a_q, b_q);
			b_q <= a_q;
			d_q <= b_q;
		end

		if (cmd.result_load) begin
			count_q <= mod_add(prod_q[SLOT_AA], prod_q[SLOT_BB]);
		end
	end

	always_comb begin
		status.small_n  = small_q;
		status.top_set  = e_q[INDEX_BITS-1];
		status.cnt_zero = (cnt_q == CW'(0));
		status.cnt_one  = (cnt_q == CW'(1));
		status.exp_bit  = e_q[INDEX_BITS-2];
		status.mul_idle = mul_idle;
	end

	assign count_mod = count_q;

endmodule

`default_nettype wire

// File: hdl/fmmp_ctrl.sv
// Controller: sequences normalization, squaring, the multiply by Q and the
// final combination, and owns the result handshake. Depends on fmmp_pkg.
`default_nettype none

module fmmp_ctrl import fmmp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	output logic         rsp_valid,
	input  logic         rsp_ready,
	input  fmmp_status_t status,
	output fmmp_cmd_t    cmd
);

	localparam logic [2:0] SQ_LAST_ISSUE  = 3'd4;
	localparam logic [2:0] FIN_LAST_ISSUE = 3'd1;

	fmmp_state_t state_q, state_d;
	logic [2:0]  issue_q, issue_d;
	logic        rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			issue_q <= issue_d;
			if (cmd.result_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		issue_d   = '0;
		cmd       = '0;
		req_ready = 1'b0;

		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_NORM;
				end
			end
			ST_NORM: begin
				if (status.small_n) begin
					state_d = ST_FIN_ISSUE;
				end else if (status.top_set) begin
					state_d = status.cnt_zero ? ST_FIN_ISSUE : ST_SQ_ISSUE;
				end else begin
					cmd.norm_shift = 1'b1;
				end
			end
			ST_SQ_ISSUE: begin
				cmd.mul_go = 1'b1;
				case (issue_q)
					3'd0:    cmd.mul_sel = MS_AA;
					3'd1:    cmd.mul_sel = MS_BB;
					3'd2:    cmd.mul_sel = MS_AB;
					3'd3:    cmd.mul_sel = MS_BD;
					default: cmd.mul_sel = MS_DD;
				endcase
				if (issue_q == SQ_LAST_ISSUE) begin
					state_d = ST_SQ_WAIT;
				end else begin
					issue_d = issue_q + 3'd1;
				end
			end
			ST_SQ_WAIT: begin
				if (status.mul_idle) begin
					state_d = ST_SQ_UPD;
				end
			end
			ST_SQ_UPD: begin
				// The bit is looked at before the update shifts it up.
				cmd.sq_update = 1'b1;
				if (status.exp_bit) begin
					state_d = ST_MULQ;
				end else if (status.cnt_one) begin
					state_d = ST_FIN_ISSUE;
				end else begin
					state_d = ST_SQ_ISSUE;
				end
			end
			ST_MULQ: begin
				cmd.q_update = 1'b1;
				state_d      = status.cnt_zero ? ST_FIN_ISSUE : ST_SQ_ISSUE;
			end
			ST_FIN_ISSUE: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = (issue_q == FIN_LAST_ISSUE) ? MS_B2 : MS_A3;
				if (issue_q == FIN_LAST_ISSUE) begin
					state_d = ST_FIN_WAIT;
				end else begin
					issue_d = issue_q + 3'd1;
				end
			end
			ST_FIN_WAIT: begin
				if (status.mul_idle) begin
					state_d = ST_FIN_ADD;
				end
			end
			ST_FIN_ADD: begin
				// Wait here only while the previous result has not been taken.
				if (!rsp_valid_q || rsp_ready) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire
